FILE: rtl/mdtc_pkg.sv
// Package for the Morse distinct-transform counter: types, constants and the Morse table.
`timescale 1ns / 1ps
`default_nettype none
package mdtc_pkg;

   localparam int MAX_LETTERS_DEF = 12;
   localparam int TABLE_DEPTH_DEF = 128;
   localparam int NUM_LETTERS     = 26;
   localparam int MORSE_BITS_W    = 4;
   localparam int MORSE_LEN_W     = 3;
   localparam int COUNT_OUT_W     = 8;

   typedef struct packed {
      logic [4:0] letter;
      logic       word_end;
      logic       list_start;
   } req_type;

   typedef struct packed {
      logic [COUNT_OUT_W-1:0] distinct_count;
      logic                   was_new;
      logic                   overflow;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Symbol bits of a letter, dash = 1, dot = 0, first symbol most significant.
   function automatic logic [MORSE_BITS_W-1:0] morse_bits(input logic [4:0] letter);
      logic [MORSE_BITS_W-1:0] bits;
      unique case (letter)
         5'd0:  bits = 4'h1;
         5'd1:  bits = 4'h8;
         5'd2:  bits = 4'hA;
         5'd3:  bits = 4'h4;
         5'd4:  bits = 4'h0;
         5'd5:  bits = 4'h2;
         5'd6:  bits = 4'h6;
         5'd7:  bits = 4'h0;
         5'd8:  bits = 4'h0;
         5'd9:  bits = 4'h7;
         5'd10: bits = 4'h5;
         5'd11: bits = 4'h4;
         5'd12: bits = 4'h3;
         5'd13: bits = 4'h2;
         5'd14: bits = 4'h7;
         5'd15: bits = 4'h6;
         5'd16: bits = 4'hD;
         5'd17: bits = 4'h2;
         5'd18: bits = 4'h0;
         5'd19: bits = 4'h1;
         5'd20: bits = 4'h1;
         5'd21: bits = 4'h1;
         5'd22: bits = 4'h3;
         5'd23: bits = 4'h9;
         5'd24: bits = 4'hB;
         5'd25: bits = 4'hC;
         default: bits = 4'h0;
      endcase
      return bits;
   endfunction

   // Number of symbols of a letter.
   function automatic logic [MORSE_LEN_W-1:0] morse_len(input logic [4:0] letter);
      logic [MORSE_LEN_W-1:0] len;
      unique case (letter)
         5'd4, 5'd19:                                    len = 3'd1;
         5'd0, 5'd8, 5'd12, 5'd13:                       len = 3'd2;
         5'd3, 5'd6, 5'd10, 5'd14, 5'd17, 5'd18, 5'd20,
         5'd22:                                          len = 3'd3;
         5'd1, 5'd2, 5'd5, 5'd7, 5'd9, 5'd11, 5'd15, 5'd16,
         5'd21, 5'd23, 5'd24, 5'd25:                     len = 3'd4;
         default:                                        len = 3'd0;
      endcase
      return len;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/morse_distinct_transform_counter.sv
// Top level of the Morse distinct-transform counter: word builder, transform table and scan.
`timescale 1ns / 1ps
`default_nettype none
//
//   Channel  Ports                         Direction  Carries
//   req      req_valid/req_stall/req_data  in         one letter with word and list flags
//   rsp      rsp_valid/rsp_stall/rsp_data  out        distinct count, new flag, overflow flag
//
// A letter that does not end a word leaves the block idle, ready for the next
// item. A word-end item is accepted, walks the transform memory one entry per
// cycle through its registered read port (a word that ran too long skips the
// walk), then inserts and loads the result; the request channel stalls until
// then. The table scan stops early at the first match. The transform memory
// needs no clearing pass: only entries below the entry count are read. Reset is
// synchronous and clears the word in progress, the entry count and the
// handshake state. A stalled result holds the finished word in the insert state
// until the output register frees.
//
module morse_distinct_transform_counter #(
   parameter int MAX_LETTERS = mdtc_pkg::MAX_LETTERS_DEF,
   parameter int TABLE_DEPTH = mdtc_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire mdtc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output mdtc_pkg::rsp_type      rsp_data
);
   import mdtc_pkg::*;

   // Each letter adds at most four symbols.
   localparam int BUF_W   = MORSE_BITS_W * MAX_LETTERS;
   localparam int LEN_W   = $clog2(BUF_W + 1);
   localparam int LCNT_W  = $clog2(MAX_LETTERS + 1);
   localparam int ENTRY_W = LEN_W + BUF_W;
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int SAT_W   = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;
   localparam logic [SAT_W-1:0] SAT_MAX = SAT_W'((1 << COUNT_OUT_W) - 1);

   // Transform memory: one entry per distinct transform, {length, bits}.
   logic [ENTRY_W-1:0] table_mem [TABLE_DEPTH];
   logic [ENTRY_W-1:0] rd_q_ff;
   logic               mem_re;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_ra;
   logic [ADDR_W-1:0]  mem_wa;

   state_type state_ff, state_in;

   // Word in progress.
   logic [BUF_W-1:0]  sym_buf_ff,  sym_buf_in;
   logic [LEN_W-1:0]  sym_len_ff,  sym_len_in;
   logic [LCNT_W-1:0] let_cnt_ff,  let_cnt_in;
   logic              too_long_ff, too_long_in;

   // Table bookkeeping and scan control.
   logic [CNT_W-1:0]  count_ff,  count_in;
   logic [CNT_W-1:0]  idx_ff,    idx_in;
   logic              pend_ff,   pend_in;
   logic              found_ff,  found_in;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff,  rsp_data_in;

   logic              req_accept;
   logic              slot_free;
   logic              scan_hit;
   logic              scan_more;
   logic              table_full;
   logic [ENTRY_W-1:0] key;

   // Letter path signals.
   logic [BUF_W-1:0]        base_buf;
   logic [LEN_W-1:0]        base_len;
   logic [LCNT_W-1:0]       base_cnt;
   logic                    base_long;
   logic [MORSE_BITS_W-1:0] m_bits;
   logic [MORSE_LEN_W-1:0]  m_len;
   logic [BUF_W-1:0]        shifted;
   logic [SAT_W-1:0]        count_wide;
   logic [CNT_W-1:0]        count_base;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign key        = {sym_len_ff, sym_buf_ff};
   assign scan_hit   = pend_ff && (rd_q_ff == key);
   assign scan_more  = (idx_ff < count_ff);
   assign table_full = (count_ff == CNT_W'(TABLE_DEPTH));
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // A list start discards the table and the word before this letter is taken.
   assign base_buf   = req_data.list_start ? '0 : sym_buf_ff;
   assign base_len   = req_data.list_start ? '0 : sym_len_ff;
   assign base_cnt   = req_data.list_start ? '0 : let_cnt_ff;
   assign base_long  = req_data.list_start ? 1'b0 : too_long_ff;
   assign count_base = req_data.list_start ? '0 : count_ff;
   assign m_bits     = morse_bits(req_data.letter);
   assign m_len      = morse_len(req_data.letter);

   // Append shift: a letter has between one and four symbols.
   always_comb begin
      unique case (m_len)
         3'd1:    shifted = base_buf << 1;
         3'd2:    shifted = base_buf << 2;
         3'd3:    shifted = base_buf << 3;
         3'd4:    shifted = base_buf << 4;
         default: shifted = base_buf;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_data.word_end) begin
               // A word that ran too long skips the table walk.
               state_in = too_long_in ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_hit || !scan_more) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      sym_buf_in   = sym_buf_ff;
      sym_len_in   = sym_len_ff;
      let_cnt_in   = let_cnt_ff;
      too_long_in  = too_long_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      found_in     = found_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_re       = 1'b0;
      mem_ra       = idx_ff[ADDR_W-1:0];
      mem_we       = 1'b0;
      mem_wa       = count_ff[ADDR_W-1:0];
      count_wide   = SAT_W'(count_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               sym_buf_in  = base_buf;
               sym_len_in  = base_len;
               let_cnt_in  = base_cnt;
               too_long_in = base_long;
               count_in    = count_base;
               if (req_data.letter < 5'(NUM_LETTERS)) begin
                  if (base_cnt >= LCNT_W'(MAX_LETTERS)) begin
                     too_long_in = 1'b1;
                  end else begin
                     sym_buf_in = shifted | BUF_W'(m_bits);
                     sym_len_in = base_len + LEN_W'(m_len);
                     let_cnt_in = base_cnt + LCNT_W'(1);
                  end
               end
               idx_in   = '0;
               found_in = 1'b0;
            end
         end
         ST_SCAN: begin
            // Compare the entry read last cycle while the next read goes out.
            if (scan_hit) begin
               found_in = 1'b1;
            end else if (scan_more) begin
               mem_re  = 1'b1;
               idx_in  = idx_ff + CNT_W'(1);
               pend_in = 1'b1;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_data_in.was_new  = 1'b0;
               rsp_data_in.overflow = 1'b0;
               if (too_long_ff) begin
                  rsp_data_in.overflow = 1'b1;
               end else if (!found_ff) begin
                  if (table_full) begin
                     rsp_data_in.overflow = 1'b1;
                  end else begin
                     mem_we               = 1'b1;
                     count_in             = count_ff + CNT_W'(1);
                     count_wide           = SAT_W'(count_ff) + SAT_W'(1);
                     rsp_data_in.was_new  = 1'b1;
                  end
               end
               rsp_data_in.distinct_count = (count_wide > SAT_MAX) ?
                  COUNT_OUT_W'(SAT_MAX) : count_wide[COUNT_OUT_W-1:0];
               rsp_valid_in = 1'b1;
               sym_buf_in   = '0;
               sym_len_in   = '0;
               let_cnt_in   = '0;
               too_long_in  = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sym_buf_ff   <= '0;
         sym_len_ff   <= '0;
         let_cnt_ff   <= '0;
         too_long_ff  <= 1'b0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sym_buf_ff   <= sym_buf_in;
         sym_len_ff   <= sym_len_in;
         let_cnt_ff   <= let_cnt_in;
         too_long_ff  <= too_long_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Transform memory, one write and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_wa] <= key;
      end
      if (mem_re) begin
         rd_q_ff <= table_mem[mem_ra];
      end
   end

endmodule
`default_nettype wire

FILE: tb/tb_morse_distinct_transform_counter.sv
// Self-checking testbench for the Morse distinct-transform counter, with its own word predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_morse_distinct_transform_counter;
   import mdtc_pkg::*;

   localparam int WORD_LETTERS   = MAX_LETTERS_DEF;
   localparam int TABLE_ENTRIES  = TABLE_DEPTH_DEF;
   // A word end walks at most every stored entry, plus accept and insert cycles.
   localparam int SCAN_CYCLES    = TABLE_ENTRIES + 8;
   // Cycles without any accepted item on either channel before the run is abandoned.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS    = 170;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   morse_distinct_transform_counter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Percentages of cycles in which the sender holds back or the receiver stalls.
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   // Predictor state: the word being built and the distinct transforms of the current list.
   logic [47:0] word_bits;
   logic [5:0]  word_len;
   int          word_letters;
   bit          word_too_long;
   logic [47:0] stored_bits [TABLE_ENTRIES];
   logic [5:0]  stored_len  [TABLE_ENTRIES];
   int          stored_count;
   int          full_table_rejects;

   // Tallies the predictor has worked out and the block has not yet delivered.
   rsp_type awaited_tallies [$];

   int sent_items;
   int tallies_checked;
   int new_words_seen;
   int overflows_seen;
   int mismatch_count;
   int quiet_cycles;

   // Morse code of each letter written out as dots and dashes.
   function automatic string morse_of(input logic [4:0] letter);
      case (letter)
         5'd0:    return ".-";
         5'd1:    return "-...";
         5'd2:    return "-.-.";
         5'd3:    return "-..";
         5'd4:    return ".";
         5'd5:    return "..-.";
         5'd6:    return "--.";
         5'd7:    return "....";
         5'd8:    return "..";
         5'd9:    return ".---";
         5'd10:   return "-.-";
         5'd11:   return ".-..";
         5'd12:   return "--";
         5'd13:   return "-.";
         5'd14:   return "---";
         5'd15:   return ".--.";
         5'd16:   return "--.-";
         5'd17:   return ".-.";
         5'd18:   return "...";
         5'd19:   return "-";
         5'd20:   return "..-";
         5'd21:   return "...-";
         5'd22:   return ".--";
         5'd23:   return "-..-";
         5'd24:   return "-.--";
         5'd25:   return "--..";
         default: return "";
      endcase
   endfunction

   function automatic void clear_word();
      word_bits     = '0;
      word_len      = '0;
      word_letters  = 0;
      word_too_long = 1'b0;
   endfunction

   // Advance the predictor by one accepted item; a word end queues the tally it produces.
   function automatic void tally_item(input req_type item);
      string   code;
      rsp_type tally;
      bit      hit;
      int      k;
      int      i;
      if (item.list_start) begin
         stored_count = 0;
         clear_word();
      end
      if (item.letter < NUM_LETTERS) begin
         if (word_letters >= WORD_LETTERS) begin
            word_too_long = 1'b1;
         end else begin
            code = morse_of(item.letter);
            for (k = 0; k < code.len(); k++) begin
               word_bits = {word_bits[46:0], code[k] == "-"};
               word_len  = word_len + 6'd1;
            end
            word_letters++;
         end
      end
      if (item.word_end) begin
         tally = '0;
         hit   = 1'b0;
         if (word_too_long) begin
            tally.overflow = 1'b1;
         end else begin
            for (i = 0; i < stored_count; i++) begin
               if (stored_bits[i] == word_bits && stored_len[i] == word_len) begin
                  hit = 1'b1;
               end
            end
            if (!hit) begin
               if (stored_count >= TABLE_ENTRIES) begin
                  tally.overflow = 1'b1;
                  full_table_rejects++;
               end else begin
                  stored_bits[stored_count] = word_bits;
                  stored_len[stored_count]  = word_len;
                  stored_count++;
                  tally.was_new = 1'b1;
               end
            end
         end
         tally.distinct_count = (stored_count > 255) ? 8'd255 : 8'(stored_count);
         awaited_tallies.push_back(tally);
         clear_word();
      end
   endfunction

   // Offer one item on the request channel and return at the edge that accepts it.
   // Valid is only ever changed at a falling edge, and never depends on the stall.
   task automatic send_item(input req_type item);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      sent_items++;
      tally_item(item);
   endtask

   // Send a lowercase word letter by letter; fresh_list raises the list start on its first letter.
   task automatic send_word(input string text, input bit fresh_list);
      req_type item;
      int      n;
      for (n = 0; n < text.len(); n++) begin
         item.letter     = 5'(text[n] - "a");
         item.word_end   = (n == text.len() - 1);
         item.list_start = fresh_list && (n == 0);
         send_item(item);
      end
   endtask

   task automatic send_raw(input logic [4:0] letter, input bit word_end, input bit list_start);
      req_type item;
      item.letter     = letter;
      item.word_end   = word_end;
      item.list_start = list_start;
      send_item(item);
   endtask

   // One random word. Most are well formed; some carry stray out-of-range letters, run past
   // the letter limit, end on an out-of-range letter, or restart the list halfway through.
   task automatic send_random_word();
      int pick;
      int len;
      int restart_at;
      bit fresh;
      int n;
      pick = $urandom_range(99);
      if (pick < 70) begin
         len = $urandom_range(6, 1);
      end else if (pick < 90) begin
         len = $urandom_range(WORD_LETTERS, 7);
      end else begin
         len = $urandom_range(WORD_LETTERS + 3, WORD_LETTERS + 1);
      end
      restart_at = ($urandom_range(99) < 4) ? $urandom_range(len - 1, 0) : -1;
      fresh      = ($urandom_range(99) < 5);
      for (n = 0; n < len; n++) begin
         if ($urandom_range(99) < 6) begin
            send_raw(5'($urandom_range(31, NUM_LETTERS)), 1'b0, 1'b0);
         end
         if (n == len - 1 && $urandom_range(99) < 3) begin
            send_raw(5'($urandom_range(31, NUM_LETTERS)), 1'b1, 1'b0);
         end else begin
            send_raw(5'($urandom_range(NUM_LETTERS - 1)), n == len - 1,
                     (fresh && n == 0) || n == restart_at);
         end
      end
   endtask

   // Extremes of the letter field, repeats, empty words, a list restart in the middle of a
   // word and a word one letter over the limit.
   task automatic test_directed();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_word("a", 1'b1);
      // "e" followed by "t" spells dot-dash, the same transform as "a".
      send_word("et", 1'b0);
      send_word("z", 1'b0);
      send_word("z", 1'b0);
      // Out-of-range letters add nothing, so these are empty words.
      send_raw(5'd31, 1'b1, 1'b0);
      send_raw(5'(NUM_LETTERS), 1'b1, 1'b0);
      // The unfinished "b" is thrown away by the list start on the next item.
      send_raw(5'd1, 1'b0, 1'b0);
      send_word("e", 1'b1);
      send_word("abcdefghijklm", 1'b0);
      send_raw(5'd30, 1'b0, 1'b0);
      send_word("t", 1'b0);
   endtask

   // Fill one list past the table depth, then confirm a stored word still matches.
   task automatic test_table_full();
      int n;
      string text;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_word("e", 1'b1);
      while (full_table_rejects < 6) begin
         text = "wxyz";
         for (n = 0; n < 4; n++) begin
            text[n] = 8'("a" + $urandom_range(NUM_LETTERS - 1));
         end
         send_word(text, 1'b0);
      end
      send_word("e", 1'b0);
   endtask

   task automatic run_random_phase(input int sender_pct, input int receiver_pct);
      int first_item;
      sender_idle_pct    = sender_pct;
      receiver_stall_pct = receiver_pct;
      first_item         = sent_items;
      while (sent_items - first_item < PHASE_ITEMS) begin
         send_random_word();
      end
   endtask

   // Random traffic in four idling phases: none, slow sender, slow receiver, and both.
   task automatic test_random_traffic();
      run_random_phase(0, 0);
      run_random_phase(84, 0);
      run_random_phase(0, 84);
      run_random_phase(27, 27);
   endtask

   // The receiver decides at each falling edge whether to stall the next edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   function automatic void check_field(input string field, input int expected, input int actual);
      if (expected != actual) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expected, actual);
         mismatch_count++;
      end
   endfunction

   // Every accepted result is compared with the oldest tally still awaited.
   always @(posedge clock) begin
      rsp_type expected;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_tallies.size() == 0) begin
            $display("%0t: unexpected result, expected none, got count %0d new %0b overflow %0b",
                     $time, rsp_data.distinct_count, rsp_data.was_new, rsp_data.overflow);
            mismatch_count++;
         end else begin
            expected = awaited_tallies.pop_front();
            check_field("distinct_count", expected.distinct_count, rsp_data.distinct_count);
            check_field("was_new", expected.was_new, rsp_data.was_new);
            check_field("overflow", expected.overflow, rsp_data.overflow);
            tallies_checked++;
            new_words_seen += rsp_data.was_new;
            overflows_seen += rsp_data.overflow;
         end
      end
   end

   // The watchdog ends a run in which neither channel moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clear_word();
      stored_count       = 0;
      full_table_rejects = 0;
      sent_items         = 0;
      tallies_checked    = 0;
      new_words_seen     = 0;
      overflows_seen     = 0;
      mismatch_count     = 0;
      quiet_cycles       = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_table_full();
      test_random_traffic();

      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_tallies.size() != 0) @(posedge clock);
      // Give the block time to show any stray result after the last expected one.
      repeat (SCAN_CYCLES) @(posedge clock);

      $display("Sent %0d letter items and checked %0d word tallies (%0d new, %0d overflow).",
               sent_items, tallies_checked, new_words_seen, overflows_seen);
      $display("Traffic covered a full table, over-long words and four idling mixes.");
      if (mismatch_count == 0 && awaited_tallies.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/mdtc_pkg.sv
rtl/morse_distinct_transform_counter.sv
tb/tb_morse_distinct_transform_counter.sv
